### rtl/mtdp_pkg.sv
`default_nettype none
package mtdp_pkg;

  localparam int MAX_PARTS_DEF = 16;
  localparam int NAME_MAX_DEF  = 32;
  localparam int NRES          = 3;
  localparam int QDEPTH        = 2;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_COLON = 2'd1,
    ERR_NAME     = 2'd2,
    ERR_EMPTY    = 2'd3
  } err_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LK    = 8'h6b;
  localparam logic [7:0] CH_UK    = 8'h4b;
  localparam logic [7:0] CH_LM    = 8'h6d;
  localparam logic [7:0] CH_UM    = 8'h4d;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_UG    = 8'h47;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  idx;
    logic [31:0] start;
    logic [31:0] size;
    logic [7:0]  ch;
    logic [4:0]  pos;
    logic        ovf;
    logic [4:0]  cnt;
    err_t        err;
  } rec_t;

  typedef struct packed {
    rec_t [NRES-1:0] recs;
    logic [1:0]      n;
  } grp_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

### rtl/mtdp_front.sv
`default_nettype none
module mtdp_front #(
  parameter int MAX_PARTS = mtdp_pkg::MAX_PARTS_DEF,
  parameter int NAME_MAX  = mtdp_pkg::NAME_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_char_byte,
  input  wire logic             in_last,
  input  wire logic [1:0]       bus_select,
  input  wire mtdp_pkg::q_stat_t q_stat,
  output logic                  push,
  output mtdp_pkg::grp_t        push_grp
);
  import mtdp_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SEEK_BUS,
    PH_SEEK_COLON,
    PH_PARSE,
    PH_STOPPED
  } phase_t;

  typedef enum logic [2:0] {
    FS_EXPECT_SIZE,
    FS_SIZE_DIGITS,
    FS_AFTER_UNIT,
    FS_START_DIGITS,
    FS_NAME,
    FS_DONE_ENTRY
  } fstep_t;

  typedef struct packed {
    phase_t      phase;
    fstep_t      fs;
    logic [31:0] rs;
    logic [31:0] es;
    logic [31:0] esz;
    logic [4:0]  cnt;
    logic [4:0]  nlen;
    logic        ovf;
    logic        segne;
    err_t        errl;
  } st_t;

  st_t  s_r, s_nxt;
  grp_t grp;
  logic acc;

  function automatic st_t cleared();
    st_t s;
    s       = '0;
    s.phase = PH_START;
    s.fs    = FS_EXPECT_SIZE;
    s.errl  = ERR_OK;
    return s;
  endfunction

  function automatic void put(inout grp_t g, input kind_t k, input logic [4:0] idx,
                              input logic [31:0] st, input logic [31:0] sz,
                              input logic [7:0] ch, input logic [4:0] pos,
                              input logic ovf, input logic [4:0] cnt, input err_t err);
    rec_t r;
    r.kind  = k;
    r.idx   = idx[3:0];
    r.start = st;
    r.size  = sz;
    r.ch    = ch;
    r.pos   = pos;
    r.ovf   = ovf;
    r.cnt   = cnt;
    r.err   = err;
    if (g.n < 2'(NRES)) begin
      g.recs[g.n] = r;
      g.n = g.n + 2'd1;
    end
  endfunction

  function automatic void mul10(inout logic [31:0] v, inout logic ovf, input logic [3:0] d);
    logic [35:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {32'b0, d};
    if (t[35:32] != 4'd0) ovf = 1'b1;
    v = t[31:0];
  endfunction

  function automatic void mul_scale(inout logic [31:0] v, inout logic ovf,
                                    input logic [1:0] sc);
    logic [63:0] t;
    case (sc)
      2'd1:    t = {22'b0, v, 10'b0};
      2'd2:    t = {12'b0, v, 20'b0};
      2'd3:    t = {2'b0, v, 30'b0};
      default: t = {32'b0, v};
    endcase
    if (t[63:32] != 32'd0) ovf = 1'b1;
    v = t[31:0];
  endfunction

  function automatic void close_entry(inout st_t s, inout grp_t g);
    logic [32:0] sum;
    put(g, KIND_ENTRY, s.cnt, s.es, s.esz, 8'd0, 5'd0, s.ovf, 5'd0, ERR_OK);
    sum = {1'b0, s.es} + {1'b0, s.esz};
    if (sum[32]) s.ovf = 1'b1;
    s.rs  = sum[31:0];
    s.cnt = s.cnt + 5'd1;
    if (s.cnt >= 5'(MAX_PARTS)) s.phase = PH_STOPPED;
    else s.fs = FS_DONE_ENTRY;
  endfunction

  function automatic void new_segment(inout st_t s);
    s.fs    = FS_EXPECT_SIZE;
    s.es    = s.rs;
    s.esz   = 32'd0;
    s.nlen  = 5'd0;
    s.segne = 1'b0;
  endfunction

  function automatic void fail_name(inout st_t s);
    s.phase = PH_STOPPED;
    s.errl  = ERR_NAME;
  endfunction

  function automatic void parse_byte(inout st_t s, inout grp_t g, input logic [7:0] c);
    logic       sep;
    logic       dig;
    logic [3:0] d;
    logic [1:0] sc;
    sep = (c == CH_COMMA) || (c == CH_SEMI);
    dig = (c >= CH_0) && (c <= CH_9);
    d   = dig ? 4'(c - CH_0) : 4'd0;
    if (c == CH_LK || c == CH_UK) sc = 2'd1;
    else if (c == CH_LM || c == CH_UM) sc = 2'd2;
    else if (c == CH_LG || c == CH_UG) sc = 2'd3;
    else sc = 2'd0;
    if (!sep) s.segne = 1'b1;
    case (s.fs)
      FS_EXPECT_SIZE, FS_SIZE_DIGITS: begin
        if (dig) begin
          if (s.fs == FS_EXPECT_SIZE) s.esz = {28'd0, d};
          else mul10(s.esz, s.ovf, d);
          s.fs = FS_SIZE_DIGITS;
        end else if (c == CH_DASH && s.fs == FS_EXPECT_SIZE) begin
          s.esz = 32'd0;
          s.fs  = FS_AFTER_UNIT;
        end else if (sc != 2'd0) begin
          mul_scale(s.esz, s.ovf, sc);
          s.fs = FS_AFTER_UNIT;
        end else if (c == CH_AT) begin
          s.es = 32'd0;
          s.fs = FS_START_DIGITS;
        end else if (c == CH_LP) begin
          s.fs = FS_NAME;
        end else begin
          fail_name(s);
        end
      end
      FS_AFTER_UNIT: begin
        if (c == CH_AT) begin
          s.es = 32'd0;
          s.fs = FS_START_DIGITS;
        end else if (c == CH_LP) begin
          s.fs = FS_NAME;
        end else begin
          fail_name(s);
        end
      end
      FS_START_DIGITS: begin
        if (dig) mul10(s.es, s.ovf, d);
        else if (c == CH_LP) s.fs = FS_NAME;
        else fail_name(s);
      end
      FS_NAME: begin
        if (c == CH_RP) begin
          close_entry(s, g);
        end else if (sep) begin
          close_entry(s, g);
          if (s.phase == PH_PARSE) new_segment(s);
        end else begin
          put(g, KIND_NAME, s.cnt, 32'd0, 32'd0, c, s.nlen, s.ovf, 5'd0, ERR_OK);
          s.nlen = s.nlen + 5'd1;
          if (s.nlen >= 5'(NAME_MAX - 1)) close_entry(s, g);
        end
      end
      default: begin
        if (sep) new_segment(s);
      end
    endcase
  endfunction

  function automatic void process(inout st_t s, inout grp_t g, input logic [7:0] c,
                                  input logic [1:0] bsel);
    logic done;
    done = 1'b0;
    if (s.phase == PH_START) s.phase = PH_SEEK_BUS;
    if (s.phase == PH_SEEK_BUS) begin
      if (bsel == 2'd1 || bsel == 2'd2) begin
        if (c == CH_0 + {6'd0, bsel}) s.phase = PH_SEEK_COLON;
        done = 1'b1;
      end else begin
        s.phase = PH_SEEK_COLON;
      end
    end
    if (!done) begin
      if (s.phase == PH_SEEK_COLON) begin
        if (c == CH_COLON) begin
          s.phase = PH_PARSE;
          new_segment(s);
        end
      end else if (s.phase == PH_PARSE) begin
        parse_byte(s, g, c);
      end
    end
  endfunction

  function automatic void finish(inout st_t s, inout grp_t g);
    err_t e;
    e = ERR_OK;
    case (s.phase)
      PH_START:                  e = ERR_EMPTY;
      PH_SEEK_BUS, PH_SEEK_COLON: e = ERR_NO_COLON;
      PH_PARSE: begin
        if (s.fs == FS_NAME) close_entry(s, g);
        else if (s.fs != FS_EXPECT_SIZE && s.fs != FS_DONE_ENTRY) e = ERR_NAME;
      end
      default:                   e = s.errl;
    endcase
    put(g, KIND_FINISH, 5'd0, 32'd0, 32'd0, 8'd0, 5'd0, s.ovf, s.cnt, e);
    s = cleared();
  endfunction

  always_comb begin
    st_t  s;
    grp_t g;
    s = s_r;
    g = '0;
    if (in_char_byte == CH_NUL) begin
      finish(s, g);
    end else begin
      process(s, g, in_char_byte, bus_select);
      if (in_last) finish(s, g);
    end
    s_nxt = s;
    grp   = g;
  end

  assign in_stall = q_stat.full;
  assign acc      = in_valid & ~q_stat.full;
  assign push     = acc && (grp.n != 2'd0);
  assign push_grp = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= cleared();
    end else if (acc) begin
      s_r <= s_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/mtdp_fifo.sv
`default_nettype none
module mtdp_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mtdp_pkg::grp_t push_grp,
  input  wire logic          pop,
  output mtdp_pkg::grp_t     head,
  output mtdp_pkg::q_stat_t  q_stat
);
  import mtdp_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  grp_t          mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign q_stat.empty = (cnt_r == CW'(0));
  assign q_stat.full  = (cnt_r == CW'(QDEPTH));
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign head         = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_pop) rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

### rtl/mtdp_back.sv
`default_nettype none
module mtdp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtdp_pkg::q_stat_t q_stat,
  input  wire mtdp_pkg::grp_t    head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mtdp_pkg::rec_t         out_rec,
  output logic                   out_last
);
  import mtdp_pkg::*;

  grp_t       cur_r;
  logic       cur_v_r;
  logic [1:0] idx_r;
  logic       take, last_take, load;

  assign out_valid = cur_v_r;
  assign out_rec   = cur_r.recs[idx_r];
  assign out_last  = (idx_r == 2'(cur_r.n - 2'd1));
  assign take      = cur_v_r & ~out_stall;
  assign last_take = take & out_last;
  assign load      = (~cur_v_r | last_take) & ~q_stat.empty;
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (load) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      cur_v_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (last_take) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/mtd_partition_string_parser_core.sv
`default_nettype none
// mtdparts string parser. one string byte is taken per clock while the result queue has
// room; the byte is classified and its results (up to three: name character, entry record,
// finish) are computed in that same cycle and queued as one group. results leave one per
// clock while out_stall is low, and bytes with one or no result sustain one per cycle.
// the queue holds two groups, and the output register holds the group being drained.
// bus_select may only be written while the block is idle.
module mtd_partition_string_parser_core #(
  parameter int MAX_PARTS = mtdp_pkg::MAX_PARTS_DEF,
  parameter int NAME_MAX  = mtdp_pkg::NAME_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_part_index,
  output logic [31:0]      out_part_start,
  output logic [31:0]      out_part_size,
  output logic [7:0]       out_name_char,
  output logic [4:0]       out_name_pos,
  output logic             out_overflow,
  output logic [4:0]       out_part_count,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_bus_select
);
  import mtdp_pkg::*;

  logic [1:0] bus_r;
  logic       push, pop;
  grp_t       push_grp, head;
  q_stat_t    q_stat;
  rec_t       rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      bus_r <= cfg_bus_select;
    end
  end

  mtdp_front #(
    .MAX_PARTS (MAX_PARTS),
    .NAME_MAX  (NAME_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_last      (in_last),
    .bus_select   (bus_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_grp     (push_grp)
  );

  mtdp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mtdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (rec),
    .out_last  (out_last_of_run)
  );

  assign out_kind       = rec.kind;
  assign out_part_index = rec.idx;
  assign out_part_start = rec.start;
  assign out_part_size  = rec.size;
  assign out_name_char  = rec.ch;
  assign out_name_pos   = rec.pos;
  assign out_overflow   = rec.ovf;
  assign out_part_count = rec.cnt;
  assign out_error_code = rec.err;

endmodule
`default_nettype wire
